/* rtl/cdq_pkg.sv */
// cdq_pkg: shared types and constants for the circular deque.
// Sizes, request opcodes, the per-cell command and the result widening helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int CAP_W      = 5;
	localparam int OUT_W      = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// Request opcodes
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_PEEK_FRONT = 3'd4,
		OP_PEEK_REAR  = 3'd5
	} op_t;

	// What every cell does this cycle
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHIFT_IN_LEFT,
		CELL_FILL_FIRST_FREE,
		CELL_SHIFT_IN_RIGHT,
		CELL_DROP_REAR,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t              kind;
		logic [DATA_WIDTH-1:0] data;
	} cell_cmd_t;

	// Sign-extend a stored entry to the 32-bit result field
	function automatic logic [OUT_W-1:0] widen(input logic [DATA_WIDTH-1:0] d);
		logic [63:0] ext;
		ext = 64'(signed'(d));
		return ext[OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/circular_deque.sv */
// circular_deque: top level of the double-ended queue.
// Control, capacity register and result register around a chain of cdq_cell.
// Depends on cdq_pkg and cdq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                         Contents
// request   in         s_tvalid s_tready s_tdata[39:0] opcode, value_in
// result    out        m_tvalid m_tready m_tdata[39:0] ok, value_out, is_empty, is_full
// config    in         cfg_we cfg_wdata[4:0]           capacity_in_use
//
// One request per cycle: the request is decoded against the entry count
// and the cell chain in the cycle it is accepted, and its result lands in
// the output register on the next edge. s_tready is low only while a result
// waits in that register and m_tready is low, so a stall on the result side
// stops the request side in the same cycle. Reset (arst_n low) empties the
// chain and sets the capacity to 16. A capacity write also empties it.
// Entries sit in order in the chain: cell 0 is the front, the last
// occupied cell the rear. Pushes and pops at the front shift the whole row.

module circular_deque (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// request: [2:0] opcode, [34:3] value_in, [39:35] zero
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [39:0]               s_tdata,
	// result: [0] ok, [32:1] value_out, [33] is_empty, [34] is_full, [39:35] zero
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	output logic      [39:0]               m_tdata,
	// capacity register
	input  wire logic                      cfg_we,
	input  wire logic [cdq_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int DW = cdq_pkg::DATA_WIDTH;
	localparam int NC = cdq_pkg::DEPTH;
	localparam int CW = cdq_pkg::CNT_W;
	localparam int OW = cdq_pkg::OUT_W;

	// ---------------- registers ----------------
	logic [cdq_pkg::CAP_W-1:0] cap_q;
	logic [CW-1:0]             count_q;
	logic                      out_valid_q;
	logic [39:0]               out_data_q;

	// ---------------- request fields ----------------
	logic [2:0]    opcode;
	logic [31:0]   value_in;
	logic [DW-1:0] push_val;
	logic          accept;

	assign opcode   = s_tdata[2:0];
	assign value_in = s_tdata[34:3];
	assign push_val = DW'(value_in);   // keep the low DATA_WIDTH bits

	assign s_tready = ~out_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	// ---------------- cell chain ----------------
	cdq_pkg::cell_cmd_t cmd;
	logic [DW-1:0] cell_data [NC];
	logic [NC-1:0] cell_occ;
	logic [NC-1:0] cell_rear;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		logic [DW-1:0] l_data, r_data;
		logic          l_occ, r_occ;

		if (i == 0) begin : g_first
			// the front cell takes a pushed value from the command and
			// always counts its left side as occupied
			assign l_data = cmd.data;
			assign l_occ  = 1'b1;
		end else begin : g_mid
			assign l_data = cell_data[i-1];
			assign l_occ  = cell_occ[i-1];
		end

		if (i == NC - 1) begin : g_last
			assign r_data = '0;
			assign r_occ  = 1'b0;
		end else begin : g_inner
			assign r_data = cell_data[i+1];
			assign r_occ  = cell_occ[i+1];
		end

		cdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_data  (l_data),
			.left_occ   (l_occ),
			.right_data (r_data),
			.right_occ  (r_occ),
			.data_q     (cell_data[i]),
			.occ_q      (cell_occ[i]),
			.rear       (cell_rear[i])
		);
	end

	// rear entry: exactly one cell flags itself as rear when not empty
	logic [DW-1:0] rear_val;
	always_comb begin
		rear_val = '0;
		for (int i = 0; i < NC; i++) begin
			rear_val = rear_val | (cell_data[i] & {DW{cell_rear[i]}});
		end
	end

	// ---------------- decode ----------------
	logic [CW-1:0] cap_eff;
	logic          empty, full;
	logic          res_ok;
	logic [OW-1:0] res_val;
	logic [CW-1:0] count_nxt;

	// capacity above DEPTH saturates
	assign cap_eff = (int'(cap_q) > NC) ? CW'(NC) : CW'(cap_q);
	assign empty   = (count_q == '0);
	assign full    = (count_q >= cap_eff);

	always_comb begin
		cmd.kind  = cdq_pkg::CELL_HOLD;
		cmd.data  = push_val;
		res_ok    = 1'b0;
		res_val   = '0;
		count_nxt = count_q;
		unique case (opcode)
			cdq_pkg::OP_PUSH_FRONT: begin
				if (!full) begin
					res_ok    = 1'b1;
					cmd.kind  = cdq_pkg::CELL_SHIFT_IN_LEFT;
					count_nxt = count_q + CW'(1);
				end
			end
			cdq_pkg::OP_PUSH_BACK: begin
				if (!full) begin
					res_ok    = 1'b1;
					cmd.kind  = cdq_pkg::CELL_FILL_FIRST_FREE;
					count_nxt = count_q + CW'(1);
				end
			end
			cdq_pkg::OP_POP_FRONT: begin
				if (!empty) begin
					res_ok    = 1'b1;
					res_val   = cdq_pkg::widen(cell_data[0]);
					cmd.kind  = cdq_pkg::CELL_SHIFT_IN_RIGHT;
					count_nxt = count_q - CW'(1);
				end
			end
			cdq_pkg::OP_POP_BACK: begin
				if (!empty) begin
					res_ok    = 1'b1;
					res_val   = cdq_pkg::widen(rear_val);
					cmd.kind  = cdq_pkg::CELL_DROP_REAR;
					count_nxt = count_q - CW'(1);
				end
			end
			cdq_pkg::OP_PEEK_FRONT: begin
				if (!empty) begin
					res_ok  = 1'b1;
					res_val = cdq_pkg::widen(cell_data[0]);
				end else begin
					res_val = '1;   // failed peek answers -1
				end
			end
			cdq_pkg::OP_PEEK_REAR: begin
				if (!empty) begin
					res_ok  = 1'b1;
					res_val = cdq_pkg::widen(rear_val);
				end else begin
					res_val = '1;
				end
			end
			default: begin
				// unknown opcode: nothing changes, ok and value stay zero
			end
		endcase

		if (cfg_we) begin
			cmd.kind = cdq_pkg::CELL_CLEAR;
		end else if (!accept) begin
			cmd.kind = cdq_pkg::CELL_HOLD;
		end
	end

	// ---------------- state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cdq_pkg::CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q   <= cfg_wdata;
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_nxt;
			end

			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {5'b0, (count_nxt == cap_eff), (count_nxt == '0), res_val, res_ok};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/cdq_cell.sv */
// cdq_cell: one slot of the deque chain, holding an entry and its occupied flag.
// Trades data with its left (toward front) and right (toward rear) neighbors.
// Depends on cdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdq_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdq_pkg::cell_cmd_t            cmd,
	input  wire logic [cdq_pkg::DATA_WIDTH-1:0] left_data,
	input  wire logic                          left_occ,
	input  wire logic [cdq_pkg::DATA_WIDTH-1:0] right_data,
	input  wire logic                          right_occ,
	output logic      [cdq_pkg::DATA_WIDTH-1:0] data_q,
	output logic                               occ_q,
	output logic                               rear
);

	// last occupied slot of the chain
	assign rear = occ_q & ~right_occ;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (cmd.kind)
				cdq_pkg::CELL_SHIFT_IN_LEFT:   occ_q <= left_occ;
				cdq_pkg::CELL_FILL_FIRST_FREE: occ_q <= occ_q | left_occ;
				cdq_pkg::CELL_SHIFT_IN_RIGHT:  occ_q <= right_occ;
				cdq_pkg::CELL_DROP_REAR:       occ_q <= occ_q & right_occ;
				cdq_pkg::CELL_CLEAR:           occ_q <= 1'b0;
				default:                       occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.kind)
			cdq_pkg::CELL_SHIFT_IN_LEFT: data_q <= left_data;
			cdq_pkg::CELL_FILL_FIRST_FREE: begin
				if (!occ_q && left_occ) data_q <= cmd.data;
			end
			cdq_pkg::CELL_SHIFT_IN_RIGHT: data_q <= right_data;
			default: data_q <= data_q;
		endcase
	end

endmodule

`default_nettype wire

/* sim/circular_deque_tb.sv */
// circular_deque_tb: self-checking bench for the circular deque over its stream ports.
// A shadow deque predicts each result; directed cases come first, then random traffic.
// Depends on cdq_pkg and circular_deque.
`timescale 1ns / 1ps

module circular_deque_tb;

	// opcodes the block must answer with a no-op result
	localparam logic [2:0] OP_NONE_LO = 3'd6;
	localparam logic [2:0] OP_NONE_HI = 3'd7;

	localparam logic [31:0] EDGE_VALUES [5] = '{
		32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
	};

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
	// traffic mix, rotated every few requests so the deque both fills and drains
	typedef enum int {TILT_FILL, TILT_DRAIN, TILT_MIXED} tilt_t;

	typedef struct {
		logic        ok;
		logic [31:0] value;
		logic        empty;
		logic        full;
	} deque_result_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        s_tvalid  = 1'b0;
	logic                        s_tready;
	logic [39:0]                 s_tdata   = '0;
	logic                        m_tvalid;
	logic                        m_tready  = 1'b0;
	logic [39:0]                 m_tdata;
	logic                        cfg_we    = 1'b0;
	logic [cdq_pkg::CAP_W-1:0]   cfg_wdata = '0;

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int errors         = 0;
	int n_sent         = 0;
	int n_ok           = 0;
	int n_full         = 0;
	int n_caps         = 0;

	deque_result_t awaited_results[$];

	// shadow deque: a ring with head and tail pointers, with the same capacity as the block
	logic [cdq_pkg::DATA_WIDTH-1:0] shadow_ring [cdq_pkg::DEPTH];
	int unsigned                    shadow_head  = 0;
	int unsigned                    shadow_tail  = 0;
	int unsigned                    shadow_count = 0;
	logic [cdq_pkg::CAP_W-1:0]      shadow_cap   = cdq_pkg::CAP_RESET;

	circular_deque u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Apply one request to the shadow deque and return the result it must produce.
	function automatic deque_result_t apply_request(input logic [2:0] op,
			input logic [31:0] val);
		deque_result_t                  r;
		int unsigned                    lim;
		int unsigned                    idx;
		logic                           hit;
		logic [cdq_pkg::DATA_WIDTH-1:0] word;
		// capacities above the store size clamp to it
		lim     = (shadow_cap > cdq_pkg::DEPTH) ? cdq_pkg::DEPTH : shadow_cap;
		r.ok    = 1'b0;
		r.value = '0;
		hit     = 1'b0;
		word    = '0;
		case (op)
			cdq_pkg::OP_PUSH_FRONT: if (shadow_count < lim) begin
				shadow_head = (shadow_head == 0) ? lim - 1 : shadow_head - 1;
				shadow_ring[shadow_head] = val[cdq_pkg::DATA_WIDTH-1:0];
				shadow_count++;
				r.ok = 1'b1;
			end
			cdq_pkg::OP_PUSH_BACK: if (shadow_count < lim) begin
				shadow_ring[shadow_tail] = val[cdq_pkg::DATA_WIDTH-1:0];
				shadow_tail = (shadow_tail + 1 >= lim) ? 0 : shadow_tail + 1;
				shadow_count++;
				r.ok = 1'b1;
			end
			cdq_pkg::OP_POP_FRONT: if (shadow_count != 0) begin
				word = shadow_ring[shadow_head];
				hit  = 1'b1;
				shadow_head = (shadow_head + 1 >= lim) ? 0 : shadow_head + 1;
				shadow_count--;
			end
			cdq_pkg::OP_POP_BACK: if (shadow_count != 0) begin
				shadow_tail = (shadow_tail == 0) ? lim - 1 : shadow_tail - 1;
				word = shadow_ring[shadow_tail];
				hit  = 1'b1;
				shadow_count--;
			end
			// a peek on an empty deque answers all ones
			cdq_pkg::OP_PEEK_FRONT: if (shadow_count != 0) begin
				word = shadow_ring[shadow_head];
				hit  = 1'b1;
			end else begin
				r.value = '1;
			end
			cdq_pkg::OP_PEEK_REAR: if (shadow_count != 0) begin
				idx  = (shadow_tail == 0) ? lim - 1 : shadow_tail - 1;
				word = shadow_ring[idx];
				hit  = 1'b1;
			end else begin
				r.value = '1;
			end
			default: ;
		endcase
		if (hit) begin
			r.ok    = 1'b1;
			r.value = 32'($signed(word));
		end
		r.empty = (shadow_count == 0);
		r.full  = (shadow_count == lim);
		return r;
	endfunction

	// Compare one accepted result with the oldest prediction.
	task automatic check_result(input logic [39:0] d);
		deque_result_t want;
		if (awaited_results.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, got %h", $time, d);
			return;
		end
		want = awaited_results[0];
		awaited_results.delete(0);
		if (d[0] !== want.ok) begin
			errors++;
			$display("%0t: ok expected %0b got %0b", $time, want.ok, d[0]);
		end
		if (d[32:1] !== want.value) begin
			errors++;
			$display("%0t: value_out expected %h got %h", $time, want.value, d[32:1]);
		end
		if (d[33] !== want.empty) begin
			errors++;
			$display("%0t: is_empty expected %0b got %0b", $time, want.empty, d[33]);
		end
		if (d[34] !== want.full) begin
			errors++;
			$display("%0t: is_full expected %0b got %0b", $time, want.full, d[34]);
		end
		if (want.ok)
			n_ok++;
		if (want.full)
			n_full++;
	endtask

	// Result side: ready decided at the edge, handshake read at the
	// falling edge before it, where every signal is settled.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata);
	end

	task automatic set_idle(input idle_mode_t mode);
		send_gap_pct   = (mode == IDLE_SEND) ? 62 : (mode == IDLE_BOTH) ? 8 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 62 : (mode == IDLE_BOTH) ? 8 : 0;
	endtask

	// Offer one request, with random gaps ahead of it, and hold it until taken.
	task automatic send_request(input logic [2:0] op, input logic [31:0] val);
		logic taken;
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, val, op};
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		awaited_results.insert(awaited_results.size(), apply_request(op, val));
		n_sent++;
	endtask

	// Stop offering and let every outstanding result come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (awaited_results.size() != 0);
	endtask

	// Capacity writes happen only with the block idle; a write also empties the deque.
	task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] cap);
		wait_drained();
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we       <= 1'b0;
		shadow_cap   = cap;
		shadow_head  = 0;
		shadow_tail  = 0;
		shadow_count = 0;
		n_caps++;
	endtask

	// Right after reset: every pop and peek must fail on the empty deque.
	task automatic test_empty_after_reset();
		send_request(cdq_pkg::OP_POP_FRONT, 32'h1234_5678);
		send_request(cdq_pkg::OP_POP_BACK, 32'h0);
		send_request(cdq_pkg::OP_PEEK_FRONT, 32'h0);
		send_request(cdq_pkg::OP_PEEK_REAR, 32'hFFFF_FFFF);
	endtask

	// Extreme values in at both ends, peeks, the two unused opcodes, then out again.
	task automatic test_both_ends();
		send_request(cdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
		send_request(cdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
		send_request(cdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
		send_request(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
		send_request(cdq_pkg::OP_PEEK_FRONT, 32'h0);
		send_request(cdq_pkg::OP_PEEK_REAR, 32'h0);
		send_request(OP_NONE_LO, 32'hA5A5_A5A5);
		send_request(OP_NONE_HI, 32'h5A5A_5A5A);
		send_request(cdq_pkg::OP_POP_BACK, 32'h0);
		send_request(cdq_pkg::OP_POP_FRONT, 32'h0);
		send_request(cdq_pkg::OP_POP_BACK, 32'h0);
		send_request(cdq_pkg::OP_POP_FRONT, 32'h0);
	endtask

	// Capacity 2: push to full, push refused, wrap of the tail, then a
	// capacity write on a non-empty deque must leave it empty.
	task automatic test_small_capacity();
		write_capacity(cdq_pkg::CAP_W'(2));
		send_request(cdq_pkg::OP_PUSH_BACK, 32'h0000_0011);
		send_request(cdq_pkg::OP_PUSH_BACK, 32'h0000_0022);
		send_request(cdq_pkg::OP_PUSH_FRONT, 32'h0000_0033);
		send_request(cdq_pkg::OP_POP_FRONT, 32'h0);
		send_request(cdq_pkg::OP_PUSH_BACK, 32'hC000_0044);
		send_request(cdq_pkg::OP_POP_BACK, 32'h0);
		write_capacity(cdq_pkg::CAP_W'(1));
		send_request(cdq_pkg::OP_PEEK_FRONT, 32'h0);
	endtask

	// Capacity 0: nothing succeeds and the flags read empty and full together.
	task automatic test_zero_capacity();
		write_capacity(cdq_pkg::CAP_W'(0));
		send_request(cdq_pkg::OP_PUSH_FRONT, 32'hDEAD_BEEF);
		send_request(cdq_pkg::OP_POP_BACK, 32'h0);
		send_request(cdq_pkg::OP_PEEK_FRONT, 32'h0);
	endtask

	// One phase of random requests at a given capacity and idling mode.
	task automatic run_random_phase(input int n, input logic [cdq_pkg::CAP_W-1:0] cap,
			input idle_mode_t mode, input bit hold_mid);
		tilt_t       tilt;
		int          r;
		int          push_pct;
		logic [2:0]  op;
		logic [31:0] val;
		tilt = TILT_MIXED;
		write_capacity(cap);
		set_idle(mode);
		for (int i = 0; i < n; i++) begin
			if (i % 16 == 0)
				tilt = tilt_t'($urandom_range(2));
			// sender holds off until the block has answered everything
			if (hold_mid && i == n / 2)
				wait_drained();
			push_pct = (tilt == TILT_FILL) ? 70 : (tilt == TILT_DRAIN) ? 20 : 45;
			r = $urandom_range(99);
			if (r < 2) begin
				op = $urandom_range(1) ? OP_NONE_HI : OP_NONE_LO;
			end else if (r < push_pct) begin
				op = $urandom_range(1) ? cdq_pkg::OP_PUSH_BACK : cdq_pkg::OP_PUSH_FRONT;
			end else begin
				case ($urandom_range(3))
					0:       op = cdq_pkg::OP_POP_FRONT;
					1:       op = cdq_pkg::OP_POP_BACK;
					2:       op = cdq_pkg::OP_PEEK_FRONT;
					default: op = cdq_pkg::OP_PEEK_REAR;
				endcase
			end
			val = ($urandom_range(9) == 0) ? EDGE_VALUES[$urandom_range(4)] : $urandom;
			send_request(op, val);
		end
	endtask

	// Random traffic over a spread of capacities, including ones above the
	// store size, cycling through the idling modes.
	task automatic test_random_traffic();
		int caps  [12] = '{16, 1, 31, 2, 0, 5, 16, 17, 3, 9, 1, 16};
		int sizes [12] = '{150, 120, 150, 120, 30, 130, 150, 130, 120, 130, 120, 150};
		for (int p = 0; p < 12; p++)
			run_random_phase(sizes[p], cdq_pkg::CAP_W'(caps[p]), idle_mode_t'(p % 4),
				p == 2);
		set_idle(IDLE_NONE);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_after_reset();
		test_both_ends();
		test_small_capacity();
		test_zero_capacity();
		test_random_traffic();
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Checked %0d requests across %0d capacity settings:", n_sent, n_caps);
		$display("%0d succeeded, %0d left the deque full.", n_ok, n_full);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/cdq_pkg.sv
rtl/cdq_cell.sv
rtl/circular_deque.sv
sim/circular_deque_tb.sv
